/* src/abbt_pkg.sv */
package abbt_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF = 32;
    localparam int ROT_FRAC_DEF    = 14;

    // Fixed field formats
    localparam int ENTRY_W    = 16;   // one rotation or scale entry
    localparam int PACK_W     = 48;   // three packed entries
    localparam int SCALE_FRAC = 8;    // Q8.8 scale
    localparam int Q_LIMIT_W  = 46;   // scaled vector is held to at most [-2^45, 2^45 - 1]
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;

    // Operation codes; the two remaining codes both mean a box
    localparam logic [OP_W-1:0] OP_POINT = 2'd0;
    localparam logic [OP_W-1:0] OP_DIR   = 2'd1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_COL0 = 3'd0,
        REG_ROT_COL1 = 3'd1,
        REG_ROT_COL2 = 3'd2,
        REG_SCALE    = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6
    } cfg_idx_t;

    // Reset values: identity rotation, unit scale
    localparam logic [PACK_W-1:0] ROT_COL0_RST = 48'h0000_0000_4000;
    localparam logic [PACK_W-1:0] ROT_COL1_RST = 48'h0000_4000_0000;
    localparam logic [PACK_W-1:0] ROT_COL2_RST = 48'h4000_0000_0000;
    localparam logic [PACK_W-1:0] SCALE_RST    = 48'h0100_0100_0100;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;   // scale products
        logic s2;   // rounded, clamped scaled vector
        logic s3;   // rotation products
        logic s4;   // per-axis min/max sums
        logic s5;   // output register
    } stage_en_t;

    // Width of the scaled vector after rounding and clamping
    function automatic int q_width(input int cw);
        q_width = (cw + SCALE_FRAC > Q_LIMIT_W) ? Q_LIMIT_W : cw + SCALE_FRAC;
    endfunction

    // Width of one rotation product
    function automatic int rot_prod_width(input int cw);
        rot_prod_width = q_width(cw) + ENTRY_W;
    endfunction

endpackage

/* src/abbt_scale.sv */
module abbt_scale #(
    parameter int COORD_WIDTH = abbt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                          clk,
    input  abbt_pkg::stage_en_t                           stage_en,
    input  logic [abbt_pkg::PACK_W-1:0]                   scale_xyz,
    input  logic signed [COORD_WIDTH-1:0]                 vec_min [3],
    input  logic signed [COORD_WIDTH-1:0]                 vec_max [3],
    output logic signed [abbt_pkg::q_width(COORD_WIDTH)-1:0] q_min [3],
    output logic signed [abbt_pkg::q_width(COORD_WIDTH)-1:0] q_max [3]
);
    import abbt_pkg::*;

    localparam int PW  = COORD_WIDTH + ENTRY_W;     // coordinate times scale
    localparam int QFW = PW - SCALE_FRAC;           // after the shift
    localparam int QW  = q_width(COORD_WIDTH);
    localparam logic [PW-1:0] ROUND = PW'(1) << (SCALE_FRAC - 1);
    localparam logic signed [QFW-1:0] Q_HI = QFW'((65'sd1 <<< (QW - 1)) - 65'sd1);
    localparam logic signed [QFW-1:0] Q_LO = ~Q_HI;

    logic signed [PW-1:0] prod_min_next [3];
    logic signed [PW-1:0] prod_max_next [3];
    logic signed [PW-1:0] prod_min_reg  [3];
    logic signed [PW-1:0] prod_max_reg  [3];
    logic signed [QW-1:0] q_min_next    [3];
    logic signed [QW-1:0] q_max_next    [3];
    logic signed [QW-1:0] q_min_reg     [3];
    logic signed [QW-1:0] q_max_reg     [3];

    // Round half up, drop the scale fraction, hold to the clamp range
    function automatic logic signed [QW-1:0] round_clamp(input logic signed [PW-1:0] p);
        logic [PW-1:0]         rnd;
        logic signed [QFW-1:0] qf;
        rnd = p + ROUND;
        qf  = $signed(rnd[PW-1:SCALE_FRAC]);
        if (qf > Q_HI)
        begin
            round_clamp = QW'(Q_HI);
        end
        else if (qf < Q_LO)
        begin
            round_clamp = QW'(Q_LO);
        end
        else
        begin
            round_clamp = QW'(qf);
        end
    endfunction

    // Stage 1: per-axis scale products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_min_next[i] = PW'(vec_min[i] * $signed(scale_xyz[ENTRY_W*i +: ENTRY_W]));
            prod_max_next[i] = PW'(vec_max[i] * $signed(scale_xyz[ENTRY_W*i +: ENTRY_W]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.s1)
        begin
            prod_min_reg <= prod_min_next;
            prod_max_reg <= prod_max_next;
        end
    end

    // Stage 2: rounding and clamp
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_min_next[i] = round_clamp(prod_min_reg[i]);
            q_max_next[i] = round_clamp(prod_max_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.s2)
        begin
            q_min_reg <= q_min_next;
            q_max_reg <= q_max_next;
        end
    end

    assign q_min = q_min_reg;
    assign q_max = q_max_reg;

endmodule

/* src/abbt_rotate.sv */
module abbt_rotate #(
    parameter int COORD_WIDTH = abbt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                                clk,
    input  abbt_pkg::stage_en_t                                 stage_en,
    input  logic [abbt_pkg::PACK_W-1:0]                         rot_col [3],
    input  logic signed [abbt_pkg::q_width(COORD_WIDTH)-1:0]    q_min [3],
    input  logic signed [abbt_pkg::q_width(COORD_WIDTH)-1:0]    q_max [3],
    output logic signed [abbt_pkg::rot_prod_width(COORD_WIDTH)-1:0] prod_min [3][3],
    output logic signed [abbt_pkg::rot_prod_width(COORD_WIDTH)-1:0] prod_max [3][3]
);
    import abbt_pkg::*;

    localparam int RPW = rot_prod_width(COORD_WIDTH);

    logic signed [RPW-1:0] prod_min_next [3][3];
    logic signed [RPW-1:0] prod_max_next [3][3];
    logic signed [RPW-1:0] prod_min_reg  [3][3];
    logic signed [RPW-1:0] prod_max_reg  [3][3];

    // Stage 3: entry j of column i times component i, for both box ends
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_min_next[j][i] =
                    RPW'($signed(rot_col[i][ENTRY_W*j +: ENTRY_W]) * q_min[i]);
                prod_max_next[j][i] =
                    RPW'($signed(rot_col[i][ENTRY_W*j +: ENTRY_W]) * q_max[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.s3)
        begin
            prod_min_reg <= prod_min_next;
            prod_max_reg <= prod_max_next;
        end
    end

    assign prod_min = prod_min_reg;
    assign prod_max = prod_max_reg;

endmodule

/* src/abbt_reduce.sv */
module abbt_reduce #(
    parameter int COORD_WIDTH   = abbt_pkg::COORD_WIDTH_DEF,
    parameter int ROT_FRAC_BITS = abbt_pkg::ROT_FRAC_DEF
) (
    input  logic                                                clk,
    input  abbt_pkg::stage_en_t                                 stage_en,
    input  logic signed [abbt_pkg::rot_prod_width(COORD_WIDTH)-1:0] prod_min [3][3],
    input  logic signed [abbt_pkg::rot_prod_width(COORD_WIDTH)-1:0] prod_max [3][3],
    input  logic signed [COORD_WIDTH-1:0]                       offset [3],
    input  logic                                                with_offset,
    output logic signed [COORD_WIDTH-1:0]                       out_min [3],
    output logic signed [COORD_WIDTH-1:0]                       out_max [3]
);
    import abbt_pkg::*;

    localparam int RPW = rot_prod_width(COORD_WIDTH);
    localparam int SW  = RPW + 2;                  // sum of three products
    localparam int RW  = SW - ROT_FRAC_BITS;       // after the shift
    localparam int VW  = RW + 1;                   // with the offset added
    localparam logic [SW-1:0] ROT_HALF = SW'(1) << (ROT_FRAC_BITS - 1);
    localparam logic signed [VW-1:0] OUT_HI =
        VW'((65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1);
    localparam logic signed [VW-1:0] OUT_LO = ~OUT_HI;

    logic signed [SW-1:0]          sum_lo_next [3];
    logic signed [SW-1:0]          sum_hi_next [3];
    logic signed [SW-1:0]          sum_lo_reg  [3];
    logic signed [SW-1:0]          sum_hi_reg  [3];
    logic signed [COORD_WIDTH-1:0] out_min_next [3];
    logic signed [COORD_WIDTH-1:0] out_max_next [3];
    logic signed [COORD_WIDTH-1:0] out_min_reg  [3];
    logic signed [COORD_WIDTH-1:0] out_max_reg  [3];

    // Round half up, shift out the rotation fraction, offset, saturate
    function automatic logic signed [COORD_WIDTH-1:0] finish(
        input logic signed [SW-1:0]          s,
        input logic                          add_off,
        input logic signed [COORD_WIDTH-1:0] off
    );
        logic [SW-1:0]        rnd;
        logic signed [RW-1:0] r;
        logic signed [VW-1:0] v;
        rnd = s + ROT_HALF;
        r   = $signed(rnd[SW-1:ROT_FRAC_BITS]);
        v   = VW'(r) + (add_off ? VW'(off) : VW'(0));
        if (v > OUT_HI)
        begin
            finish = COORD_WIDTH'(OUT_HI);
        end
        else if (v < OUT_LO)
        begin
            finish = COORD_WIDTH'(OUT_LO);
        end
        else
        begin
            finish = COORD_WIDTH'(v);
        end
    endfunction

    // Stage 4: the sum is separable per input axis, so the extreme corner
    // takes the smaller or larger product of each term
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum_lo_next[j] = '0;
            sum_hi_next[j] = '0;
            for (int i = 0; i < 3; i++)
            begin
                if (prod_min[j][i] < prod_max[j][i])
                begin
                    sum_lo_next[j] = sum_lo_next[j] + SW'(prod_min[j][i]);
                    sum_hi_next[j] = sum_hi_next[j] + SW'(prod_max[j][i]);
                end
                else
                begin
                    sum_lo_next[j] = sum_lo_next[j] + SW'(prod_max[j][i]);
                    sum_hi_next[j] = sum_hi_next[j] + SW'(prod_min[j][i]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.s4)
        begin
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
        end
    end

    // Stage 5: output register; rounding and offset are monotonic, so
    // extremes carry straight through
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            out_min_next[j] = finish(sum_lo_reg[j], with_offset, offset[j]);
            out_max_next[j] = finish(sum_hi_reg[j], with_offset, offset[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.s5)
        begin
            out_min_reg <= out_min_next;
            out_max_reg <= out_max_next;
        end
    end

    assign out_min = out_min_reg;
    assign out_max = out_max_reg;

endmodule

/* src/affine_bounding_box_transform_unit.sv */
// Affine box transform: out = R * (S * v) + T in fixed point (no T for directions).
// Input stream (s_axis_*): one request per item; tuser carries the op
// (point, direction, box), tdata the box minimum and maximum corners.
// For point and direction requests only the minimum corner is used.
// Output stream (m_axis_*): one result per request, the transformed box
// minimum and maximum (equal for point and direction requests).
// Configuration: write cfg_data to register cfg_index when cfg_we is high;
// rotation columns, scale, and offsets x, y, z. Write only while idle.
// Throughput: one request per cycle while m_axis_tready is high. The five
// register stages, in order: scale multiply, round and clamp, rotation
// multiply, per-axis min/max sum, round/offset/saturate.
// Each stage loads whenever the one after it is empty or moving on, so a
// stall on m_axis_tready fills bubbles first and then holds every stage;
// s_axis_tready drops only when all stages are occupied.
// Reset clears all stage valid bits and restores identity rotation, unit
// scale and zero offset.
module affine_bounding_box_transform_unit #(
    parameter int COORD_WIDTH   = abbt_pkg::COORD_WIDTH_DEF,
    parameter int ROT_FRAC_BITS = abbt_pkg::ROT_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [abbt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [((COORD_WIDTH > abbt_pkg::PACK_W) ? COORD_WIDTH
                   : abbt_pkg::PACK_W)-1:0]       cfg_data,
    // request stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, zero fill
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // op
    input  logic [abbt_pkg::OP_W-1:0]             s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z, zero fill
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata
);
    import abbt_pkg::*;

    localparam int DW = ((6*COORD_WIDTH+7)/8)*8;
    localparam int QW = q_width(COORD_WIDTH);
    localparam int RPW = rot_prod_width(COORD_WIDTH);

    logic [PACK_W-1:0]             rot_col_reg [3];
    logic [PACK_W-1:0]             scale_reg;
    logic signed [COORD_WIDTH-1:0] offset_reg [3];

    stage_en_t                     stage_en;
    logic                          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                          off_s1_reg, off_s2_reg, off_s3_reg, off_s4_reg;

    logic                          is_box;
    logic                          with_off;
    logic signed [COORD_WIDTH-1:0] in_min [3];
    logic signed [COORD_WIDTH-1:0] in_max [3];
    logic signed [QW-1:0]          q_min [3];
    logic signed [QW-1:0]          q_max [3];
    logic signed [RPW-1:0]         rprod_min [3][3];
    logic signed [RPW-1:0]         rprod_max [3][3];
    logic signed [COORD_WIDTH-1:0] res_min [3];
    logic signed [COORD_WIDTH-1:0] res_max [3];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_col_reg[0] <= ROT_COL0_RST;
            rot_col_reg[1] <= ROT_COL1_RST;
            rot_col_reg[2] <= ROT_COL2_RST;
            scale_reg      <= SCALE_RST;
            offset_reg[0]  <= '0;
            offset_reg[1]  <= '0;
            offset_reg[2]  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ROT_COL0: rot_col_reg[0] <= cfg_data[PACK_W-1:0];
                REG_ROT_COL1: rot_col_reg[1] <= cfg_data[PACK_W-1:0];
                REG_ROT_COL2: rot_col_reg[2] <= cfg_data[PACK_W-1:0];
                REG_SCALE:    scale_reg      <= cfg_data[PACK_W-1:0];
                REG_OFFSET_X: offset_reg[0]  <= $signed(cfg_data[COORD_WIDTH-1:0]);
                REG_OFFSET_Y: offset_reg[1]  <= $signed(cfg_data[COORD_WIDTH-1:0]);
                REG_OFFSET_Z: offset_reg[2]  <= $signed(cfg_data[COORD_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    // Request unpacking; point and direction use the minimum corner twice
    assign is_box   = (s_axis_tuser != OP_POINT) && (s_axis_tuser != OP_DIR);
    assign with_off = (s_axis_tuser != OP_DIR);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_min[i] = $signed(s_axis_tdata[COORD_WIDTH*i +: COORD_WIDTH]);
            in_max[i] = is_box ? $signed(s_axis_tdata[COORD_WIDTH*(3+i) +: COORD_WIDTH])
                               : in_min[i];
        end
    end

    // Stage enables: load when empty or when the next stage moves on
    always_comb
    begin
        stage_en.s5 = !v5_reg || m_axis_tready;
        stage_en.s4 = !v4_reg || stage_en.s5;
        stage_en.s3 = !v3_reg || stage_en.s4;
        stage_en.s2 = !v2_reg || stage_en.s3;
        stage_en.s1 = !v1_reg || stage_en.s2;
    end

    assign s_axis_tready = stage_en.s1;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (stage_en.s1) v1_reg <= s_axis_tvalid;
            if (stage_en.s2) v2_reg <= v1_reg;
            if (stage_en.s3) v3_reg <= v2_reg;
            if (stage_en.s4) v4_reg <= v3_reg;
            if (stage_en.s5) v5_reg <= v4_reg;
        end
    end

    // Offset flag travels with the data up to the final stage
    always_ff @(posedge clk)
    begin
        if (stage_en.s1) off_s1_reg <= with_off;
        if (stage_en.s2) off_s2_reg <= off_s1_reg;
        if (stage_en.s3) off_s3_reg <= off_s2_reg;
        if (stage_en.s4) off_s4_reg <= off_s3_reg;
    end

    abbt_scale #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
        .clk       (clk),
        .stage_en  (stage_en),
        .scale_xyz (scale_reg),
        .vec_min   (in_min),
        .vec_max   (in_max),
        .q_min     (q_min),
        .q_max     (q_max)
    );

    abbt_rotate #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rotate (
        .clk      (clk),
        .stage_en (stage_en),
        .rot_col  (rot_col_reg),
        .q_min    (q_min),
        .q_max    (q_max),
        .prod_min (rprod_min),
        .prod_max (rprod_max)
    );

    abbt_reduce #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_reduce (
        .clk         (clk),
        .stage_en    (stage_en),
        .prod_min    (rprod_min),
        .prod_max    (rprod_max),
        .offset      (offset_reg),
        .with_offset (off_s4_reg),
        .out_min     (res_min),
        .out_max     (res_max)
    );

    // Result packing
    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = DW'({res_max[2], res_max[1], res_max[0],
                                res_min[2], res_min[1], res_min[0]});

    // A full pipeline under output stall must refuse new requests
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !m_axis_tready)
        |-> !s_axis_tready)
        else $error("request accepted into a full, stalled pipeline");

    // A request into an empty pipeline passes straight through to the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !v1_reg && !v2_reg && !v3_reg
         && !v4_reg && !v5_reg) |-> ##5 m_axis_tvalid)
        else $error("result missing five cycles after request into empty pipeline");

    // Result minimum never exceeds the maximum on any axis
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((res_min[0] <= res_max[0]) && (res_min[1] <= res_max[1])
                           && (res_min[2] <= res_max[2])))
        else $error("result minimum above maximum");

endmodule
